/* sv/u8s_pkg.sv */
// ============================================================================
// UTF-8 sanitiser package
// Shared request types, the command passed from front to back, and the
// code point check.
// ============================================================================
package u8s_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_run;
        logic       end_of_text;
    } result_t;

    // Replacement characters come first, then the literal bytes.
    typedef struct packed {
        logic [2:0]      rep_count;
        logic [2:0]      lit_count;
        logic [3:0][7:0] lit_bytes;
        logic            last;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef enum logic [1:0] {
        PH_EF,
        PH_BF,
        PH_BD
    } rep_phase_t;

    function automatic logic code_ok(input logic [2:0] len, input logic [20:0] cp);
        logic ok;
        ok = 1'b1;
        if (len == 3'd2 && cp < 21'h80) ok = 1'b0;
        if (len == 3'd3 && cp < 21'h800) ok = 1'b0;
        if (len == 3'd4 && cp < 21'h10000) ok = 1'b0;
        if (cp > 21'h10FFFF) ok = 1'b0;
        if (cp >= 21'hD800 && cp <= 21'hDFFF) ok = 1'b0;
        return ok;
    endfunction

endpackage

/* sv/u8s_front.sv */
// ============================================================================
// UTF-8 sanitiser front end
// Tracks the open sequence and writes a command for each accepted byte that ends a character or a bad sequence.
// ============================================================================
module u8s_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  u8s_pkg::item_t item,
    output logic           cmd_write,
    output u8s_pkg::cmd_t  cmd
);

    logic [7:0]  held_reg [0:2];
    logic [7:0]  held_next [0:2];
    logic [1:0]  hc_reg, hc_next;
    logic [2:0]  exp_reg, exp_next;
    logic [20:0] acc_reg, acc_next;

    always_comb
    begin
        logic [7:0]  c;
        logic [2:0]  total;
        logic [20:0] acc;
        logic        do_lead;
        logic        close;
        c         = item.data_byte;
        total     = {1'b0, hc_reg} + 3'd1;
        acc       = {acc_reg[14:0], c[5:0]};
        do_lead   = 1'b0;
        close     = 1'b0;
        held_next = held_reg;
        hc_next   = hc_reg;
        exp_next  = exp_reg;
        acc_next  = acc_reg;
        cmd       = '0;
        cmd.last  = item.last_byte;

        if (exp_reg != 3'd0)
        begin
            if (c[7:6] == 2'b10)
            begin
                acc_next = acc;
                if (total >= exp_reg)
                begin
                    if (u8s_pkg::code_ok(exp_reg, acc))
                    begin
                        cmd.lit_count = total;
                        for (int i = 0; i < 3; i++)
                        begin
                            cmd.lit_bytes[i] = (hc_reg == 2'(i)) ? c : held_reg[i];
                        end
                        cmd.lit_bytes[3] = c;
                    end
                    else
                    begin
                        cmd.rep_count = total;
                    end
                    close = 1'b1;
                end
                else
                begin
                    if (hc_reg != 2'd3)
                    begin
                        held_next[hc_reg] = c;
                    end
                    hc_next = total[1:0];
                    if (item.last_byte)
                    begin
                        cmd.rep_count = total;
                        close = 1'b1;
                    end
                end
            end
            else
            begin
                cmd.rep_count = {1'b0, hc_reg};
                close = 1'b1;
                do_lead = 1'b1;
            end
        end
        else
        begin
            do_lead = 1'b1;
        end

        if (close)
        begin
            hc_next  = '0;
            exp_next = '0;
            acc_next = '0;
        end

        if (do_lead)
        begin
            if (!c[7])
            begin
                cmd.lit_bytes[0] = c;
                cmd.lit_count = 3'd1;
            end
            else if (c[7:5] == 3'b110 || c[7:4] == 4'b1110 || c[7:3] == 5'b11110)
            begin
                if (c[7:5] == 3'b110)
                begin
                    exp_next = 3'd2;
                    acc_next = {16'd0, c[4:0]};
                end
                else if (c[7:4] == 4'b1110)
                begin
                    exp_next = 3'd3;
                    acc_next = {17'd0, c[3:0]};
                end
                else
                begin
                    exp_next = 3'd4;
                    acc_next = {18'd0, c[2:0]};
                end
                held_next[0] = c;
                hc_next = 2'd1;
                if (item.last_byte)
                begin
                    cmd.rep_count = cmd.rep_count + 3'd1;
                    hc_next  = '0;
                    exp_next = '0;
                    acc_next = '0;
                end
            end
            else
            begin
                cmd.rep_count = cmd.rep_count + 3'd1;
            end
        end

        cmd_write = accept && (cmd.rep_count != 3'd0 || cmd.lit_count != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg  <= '0;
            exp_reg <= '0;
            acc_reg <= '0;
        end
        else if (accept)
        begin
            hc_reg  <= hc_next;
            exp_reg <= exp_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

/* sv/u8s_queue.sv */
// ============================================================================
// UTF-8 sanitiser command queue
// Small first-in first-out store of commands between front and back.
// ============================================================================
module u8s_queue #(
    parameter int unsigned DEPTH = u8s_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  u8s_pkg::cmd_t     wr_cmd,
    input  logic              rd_en,
    output logic              full,
    output u8s_pkg::q_head_t  head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    u8s_pkg::cmd_t   mem [0:DEPTH-1];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full       = (count_reg == CW'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("Command queue count exceeds its depth.");

    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> count_reg != '0)
        else $error("Command queue read while empty.");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("Command queue written while full.");

endmodule

/* sv/u8s_back.sv */
// ============================================================================
// UTF-8 sanitiser back end
// Expands each command into output bytes held in an output register, one per cycle
// while that register is empty or being popped.
// ============================================================================
module u8s_back (
    input  logic              clk,
    input  logic              rst_n,
    input  u8s_pkg::q_head_t  head,
    output logic              rd_en,
    input  logic              pop,
    output logic              empty,
    output u8s_pkg::result_t  result
);

    logic                 out_valid_reg;
    u8s_pkg::result_t     out_reg;
    logic [2:0]           rep_idx_reg, rep_idx_next;
    logic [2:0]           lit_idx_reg, lit_idx_next;
    u8s_pkg::rep_phase_t  phase_reg, phase_next;
    logic                 step;
    logic                 rep_done;
    logic                 cmd_end;
    logic [7:0]           byte_val;

    assign empty    = !out_valid_reg;
    assign result   = out_reg;
    assign step     = head.valid && (!out_valid_reg || pop);
    assign rep_done = (rep_idx_reg == head.cmd.rep_count);
    assign rd_en    = step && cmd_end;

    always_comb
    begin
        byte_val     = head.cmd.lit_bytes[lit_idx_reg[1:0]];
        cmd_end      = (lit_idx_reg + 3'd1 == head.cmd.lit_count);
        rep_idx_next = rep_idx_reg;
        lit_idx_next = lit_idx_reg;
        phase_next   = phase_reg;
        if (!rep_done)
        begin
            cmd_end = (phase_reg == u8s_pkg::PH_BD)
                   && (rep_idx_reg + 3'd1 == head.cmd.rep_count)
                   && (head.cmd.lit_count == 3'd0);
            case (phase_reg)
                u8s_pkg::PH_EF:
                begin
                    byte_val   = u8s_pkg::REPL_B0;
                    phase_next = u8s_pkg::PH_BF;
                end
                u8s_pkg::PH_BF:
                begin
                    byte_val   = u8s_pkg::REPL_B1;
                    phase_next = u8s_pkg::PH_BD;
                end
                u8s_pkg::PH_BD:
                begin
                    byte_val     = u8s_pkg::REPL_B2;
                    phase_next   = u8s_pkg::PH_EF;
                    rep_idx_next = rep_idx_reg + 3'd1;
                end
                default:
                begin
                    byte_val   = u8s_pkg::REPL_B0;
                    phase_next = u8s_pkg::PH_EF;
                end
            endcase
        end
        else
        begin
            lit_idx_next = lit_idx_reg + 3'd1;
        end
        if (cmd_end)
        begin
            rep_idx_next = '0;
            lit_idx_next = '0;
            phase_next   = u8s_pkg::PH_EF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rep_idx_reg   <= '0;
            lit_idx_reg   <= '0;
            phase_reg     <= u8s_pkg::PH_EF;
        end
        else
        begin
            if (step)
            begin
                out_valid_reg <= 1'b1;
                rep_idx_reg   <= rep_idx_next;
                lit_idx_reg   <= lit_idx_next;
                phase_reg     <= phase_next;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg.out_byte    <= byte_val;
            out_reg.end_of_run  <= cmd_end;
            out_reg.end_of_text <= cmd_end && head.cmd.last;
        end
    end

    a_lit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lit_idx_reg <= 3'd4)
        else $error("Literal index runs past the command.");

    a_rep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> rep_idx_reg <= head.cmd.rep_count)
        else $error("Replacement index runs past the command.");

    a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
        !head.valid |-> (rep_idx_reg == '0 && lit_idx_reg == '0))
        else $error("Expansion counters not cleared between commands.");

endmodule

/* sv/utf8_sanitizer_unit.sv */
// ============================================================================
// UTF-8 sanitiser
// Passes well-formed UTF-8 through and replaces bad sequences with U+FFFD.
//
//   channel   handshake          payload
//   input     push / full        item   (data_byte, last_byte)
//   output    pop / empty        result (out_byte, end_of_run, end_of_text)
//
// One input byte is accepted per cycle while the command queue has room.
// One output byte leaves per cycle while pop keeps up; a byte causing n results holds the back
// end until all of them have left (up to twelve bytes), which sets the sustained rate.
// The command queue holds QUEUE_DEPTH commands; full rises when it is full.
// A registered output stage lets new requests enter while a result waits.
// Reset clears the open sequence, the queue and the output stage at once.
// ============================================================================
module utf8_sanitizer_unit #(
    parameter int unsigned QUEUE_DEPTH = u8s_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  u8s_pkg::item_t    item,
    input  logic              pop,
    output logic              empty,
    output u8s_pkg::result_t  result
);

    logic              accept;
    logic              cmd_write;
    u8s_pkg::cmd_t     cmd;
    u8s_pkg::q_head_t  head;
    logic              rd_en;

    assign accept = push && !full;

    u8s_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cmd_write (cmd_write),
        .cmd       (cmd)
    );

    u8s_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_write),
        .wr_cmd (cmd),
        .rd_en  (rd_en),
        .full   (full),
        .head   (head)
    );

    u8s_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .rd_en  (rd_en),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

endmodule
